>>> hdl/bspq_pkg.sv
// ----------------------------------------------------------------------------
// bspq_pkg
// Shared constants, types and helpers for the bounded sorted priority queue.
// ----------------------------------------------------------------------------
package bspq_pkg;

	localparam int DEPTH      = 16;
	localparam int KEY_WIDTH  = 32;
	localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);

	localparam int KEY_PORT_W = 32;
	localparam int CAP_W      = 5;
	localparam int COUNT_W    = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef logic [KEY_WIDTH-1:0] key_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_EVICTED   = 3'd1,
		ST_REJECTED  = 3'd2,
		ST_POPPED    = 3'd3,
		ST_POP_EMPTY = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAPACITY   = 2'd0,
		REG_ORDER_MODE = 2'd1
	} cfg_reg_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

	// true if a has strictly higher priority than b
	function automatic logic beats(key_t a, key_t b, logic mode);
		return mode ? (a < b) : (a > b);
	endfunction

endpackage

>>> hdl/bspq_ctrl.sv
// ----------------------------------------------------------------------------
// bspq_ctrl
// Sequencer: captures one item, runs it through the datapath and manages the
// output register handshake.
// ----------------------------------------------------------------------------
module bspq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output bspq_pkg::ctrl_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd.load = (state_q == S_IDLE) && in_valid;
		// result register must be free or draining this cycle
		cmd.exec = (state_q == S_EXEC) && (!out_valid_q || !out_stall);
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.exec) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_exec_only_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q && (state_q == S_IDLE))
		else $error("result not presented after execute");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !cmd.exec)
		else $error("held result overwritten");

	a_load_starts_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_EXEC))
		else $error("captured item not executed");
`endif

endmodule

>>> hdl/bspq_dp.sv
// ----------------------------------------------------------------------------
// bspq_dp
// Datapath: sorted key array with parallel compare and shift, occupancy,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module bspq_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bspq_pkg::ctrl_cmd_t                  cmd,
	input  logic                                 op,
	input  logic [bspq_pkg::KEY_PORT_W-1:0]      key,
	input  logic                                 cfg_we,
	input  logic [bspq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bspq_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic [2:0]                           status,
	output logic [bspq_pkg::KEY_PORT_W-1:0]      out_key,
	output logic [bspq_pkg::COUNT_W-1:0]         count
);

	localparam int DEPTH = bspq_pkg::DEPTH;
	localparam int CNT_W = bspq_pkg::CNT_W;

	bspq_pkg::key_t                   entries_q [DEPTH];
	bspq_pkg::key_t                   entries_nxt [DEPTH];
	bspq_pkg::cnt_t                   occ_q;
	logic [bspq_pkg::CAP_W-1:0]       cap_q;
	logic                             mode_q;
	logic                             op_q;
	bspq_pkg::key_t                   key_q;
	bspq_pkg::status_t                status_q;
	bspq_pkg::key_t                   okey_q;
	bspq_pkg::cnt_t                   count_q;

	bspq_pkg::cnt_t                   cap_eff;
	bspq_pkg::cnt_t                   occ_t;
	bspq_pkg::cnt_t                   occ_m1;
	bspq_pkg::cnt_t                   base;
	bspq_pkg::cnt_t                   occ_nxt;
	bspq_pkg::key_t                   last_key;
	bspq_pkg::key_t                   okey_nxt;
	bspq_pkg::status_t                status_nxt;
	logic                             is_pop;
	logic                             full;
	logic                             reject;
	logic                             evict;
	logic [DEPTH-1:0]                 place;
	bspq_pkg::key_t                   ins_val [DEPTH];

	// capacity above the array depth saturates
	always_comb begin
		if (bspq_pkg::CMP_W'(cap_q) > bspq_pkg::CMP_W'(DEPTH)) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
		occ_t    = (occ_q > cap_eff) ? cap_eff : occ_q;
		occ_m1   = occ_t - CNT_W'(1);
		last_key = entries_q[occ_m1[bspq_pkg::IDX_W-1:0]];
		is_pop   = (op_q == bspq_pkg::OP_POP);
		full     = (occ_t == cap_eff);
		reject   = !is_pop && full &&
			((cap_eff == '0) || bspq_pkg::beats(last_key, key_q, mode_q));
		evict    = !is_pop && full && !reject;
		base     = evict ? occ_m1 : occ_t;
	end

	// place[i]: the new key lands at or above slot i
	for (genvar i = 0; i < DEPTH; i++) begin : g_place
		if (i == 0) begin : g_head
			assign place[i] = (CNT_W'(i) >= base) ||
				bspq_pkg::beats(key_q, entries_q[i], mode_q);
			assign ins_val[i] = place[i] ? key_q : entries_q[i];
		end else begin : g_body
			// first beaten slot wins, every later slot shifts down
			assign place[i] = place[i - 1] || (CNT_W'(i) >= base) ||
				bspq_pkg::beats(key_q, entries_q[i], mode_q);
			assign ins_val[i] = !place[i]     ? entries_q[i] :
			                    !place[i - 1] ? key_q        : entries_q[i - 1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign entries_nxt[i] = is_pop ? entries_q[i] : ins_val[i];
		end else begin : g_mid
			assign entries_nxt[i] = is_pop ? entries_q[i + 1] : ins_val[i];
		end
	end

	always_comb begin
		okey_nxt = '0;
		if (is_pop) begin
			if (occ_t == '0) begin
				status_nxt = bspq_pkg::ST_POP_EMPTY;
				occ_nxt    = occ_t;
			end else begin
				status_nxt = bspq_pkg::ST_POPPED;
				okey_nxt   = entries_q[0];
				occ_nxt    = occ_m1;
			end
		end else if (reject) begin
			status_nxt = bspq_pkg::ST_REJECTED;
			okey_nxt   = key_q;
			occ_nxt    = occ_t;
		end else if (evict) begin
			status_nxt = bspq_pkg::ST_EVICTED;
			okey_nxt   = last_key;
			occ_nxt    = base + CNT_W'(1);
		end else begin
			status_nxt = bspq_pkg::ST_INSERTED;
			occ_nxt    = base + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			cap_q  <= bspq_pkg::CAP_RESET;
			mode_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				occ_q <= occ_nxt;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					bspq_pkg::REG_CAPACITY:   cap_q  <= cfg_data[bspq_pkg::CAP_W-1:0];
					bspq_pkg::REG_ORDER_MODE: mode_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			key_q <= bspq_pkg::KEY_WIDTH'(key);
		end
		if (cmd.exec) begin
			// on a reject or empty pop the array is written back unchanged
			// only where slots stay below the occupancy, so gate the update
			if (!reject && !(is_pop && occ_t == '0)) begin
				for (int i = 0; i < DEPTH; i++) begin
					entries_q[i] <= entries_nxt[i];
				end
			end
			status_q <= status_nxt;
			okey_q   <= okey_nxt;
			count_q  <= occ_nxt;
		end
	end

	assign status  = status_q;
	assign out_key = bspq_pkg::KEY_PORT_W'(okey_q);
	assign count   = bspq_pkg::COUNT_W'(count_q);

`ifndef NO_ASSERTIONS
	a_occ_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(DEPTH))
		else $error("occupancy beyond array depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && !is_pop && !reject) |=> (occ_q == $past(base) + CNT_W'(1)))
		else $error("insert did not add one entry");

	a_zero_key: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> ((status_q != bspq_pkg::ST_INSERTED &&
		               status_q != bspq_pkg::ST_POP_EMPTY) || okey_q == '0))
		else $error("nonzero key on plain insert or empty pop");
`endif

endmodule

>>> hdl/bounded_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// bounded_sorted_priority_queue
// Bounded priority queue holding keys in a sorted register array, highest
// priority first, with push/pop items and eviction of the lowest-priority key.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  input     in_valid / in_stall    op, key
//  output    out_valid / out_stall  status, out_key, count
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  each item is captured first, then its key is compared against every entry
//  in parallel and the array shifted; a new item is accepted the cycle after
//  execute, while the previous result may still sit in the output register.
//  execute waits while that register is held by out_stall.
//  reset empties the queue, sets capacity to 16 and order_mode to 0; key
//  storage is not cleared. config writes are always ready.
//
module bounded_sorted_priority_queue (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               op,
	input  logic [bspq_pkg::KEY_PORT_W-1:0]    key,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [2:0]                         status,
	output logic [bspq_pkg::KEY_PORT_W-1:0]    out_key,
	output logic [bspq_pkg::COUNT_W-1:0]       count,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bspq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bspq_pkg::CFG_DATA_W-1:0]    cfg_data
);

	bspq_pkg::ctrl_cmd_t cmd;

	assign cfg_ready = 1'b1;

	bspq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	bspq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.op        (op),
		.key       (key),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.out_key   (out_key),
		.count     (count)
	);

endmodule
